/* rtl/u8d_pkg.sv */
// package for the utf-8 stream decoder: transaction types, commands, lead decode
`default_nettype none
package u8d_pkg;

  localparam int unsigned BufDepth = 6;
  localparam int unsigned CntW     = $clog2(BufDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  consumed;
    logic        bad_sequence;
    logic        run_end;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic emit;
  } u8d_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic more;
  } u8d_status_t;

  typedef struct packed {
    logic [CntW-1:0] need;
    logic            bad;
  } lead_t;

  function automatic lead_t lead_info(input logic [7:0] b);
    lead_t r;
    r.bad  = 1'b0;
    r.need = CntW'(1);
    if (b[7] == 1'b0) begin
      r.need = CntW'(1);
    end else if ((b & 8'hE0) == 8'hC0) begin
      r.need = CntW'(2);
    end else if ((b & 8'hF0) == 8'hE0) begin
      r.need = CntW'(3);
    end else if ((b & 8'hF8) == 8'hF0) begin
      r.need = CntW'(4);
    end else if ((b & 8'hFC) == 8'hF8) begin
      r.need = CntW'(5);
      r.bad  = 1'b1;
    end else if ((b & 8'hFE) == 8'hFC) begin
      r.need = CntW'(6);
      r.bad  = 1'b1;
    end else begin
      r.need = CntW'(1);
      r.bad  = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/u8d_datapath.sv */
// datapath: pending byte buffer, sequence decode and result register
`default_nettype none
module u8d_datapath
  import u8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_item_t    item,
  input  wire u8d_cmd_t    cmd,
  output u8d_status_t      status,
  output out_item_t        result
);

  logic [BufDepth-1:0][7:0] pend;
  logic [CntW-1:0]          count;
  logic                     at_end;

  logic [7:0]               lead;
  lead_t                    li;
  lead_t                    nli;
  logic                     complete;
  logic                     broken;
  logic [CntW-1:0]          used;
  logic [CntW-1:0]          rem;
  logic [20:0]              cp;
  logic [BufDepth-1:0][7:0] shifted;
  out_item_t                res_next;

  assign lead = pend[0];
  assign li   = lead_info(lead);
  assign complete = (li.need <= count);

  // first broken continuation within the announced length
  always_comb begin
    used   = li.need;
    broken = 1'b0;
    for (int k = 1; k < BufDepth; k++) begin
      if (!broken && (CntW'(k) < li.need) && (pend[k][7:6] != 2'b10)) begin
        broken = 1'b1;
        used   = CntW'(k);
      end
    end
    if (!complete) begin
      used = CntW'(1);
    end
  end

  always_comb begin
    case (li.need)
      CntW'(1): cp = {13'd0, lead};
      CntW'(2): cp = {10'd0, lead[4:0], pend[1][5:0]};
      CntW'(3): cp = {5'd0, lead[3:0], pend[1][5:0], pend[2][5:0]};
      CntW'(4): cp = {lead[2:0], pend[1][5:0], pend[2][5:0], pend[3][5:0]};
      default:  cp = 21'd0;
    endcase
  end

  assign rem     = count - used;
  assign shifted = pend >> {used, 3'b000};
  assign nli     = lead_info(shifted[0]);

  assign status.can_emit = (count != '0) && (complete || at_end);
  assign status.more     = (rem != '0) && ((nli.need <= rem) || at_end);

  always_comb begin
    res_next.run_end = !status.more;
    res_next.consumed = used;
    if (!complete) begin
      res_next.code_point   = {13'd0, lead};
      res_next.bad_sequence = 1'b0;
    end else if (li.bad || broken) begin
      res_next.code_point   = 21'd0;
      res_next.bad_sequence = 1'b1;
    end else begin
      res_next.code_point   = cp;
      res_next.bad_sequence = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      at_end <= 1'b0;
    end else if (cmd.load) begin
      pend[count[2:0]] <= item.data_byte;
      count            <= count + CntW'(1);
      at_end           <= item.buffer_end;
    end else if (cmd.emit) begin
      pend   <= shifted;
      count  <= rem;
      result <= res_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/u8d_ctrl.sv */
// controller: accepts a byte, then steps out one result per cycle while result_stall is low
`default_nettype none
module u8d_ctrl
  import u8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  output logic             result_valid,
  input  wire logic        result_stall,
  input  wire u8d_status_t status,
  output u8d_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next        = state;
    result_valid_next = result_valid && result_stall;
    cmd               = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!(result_valid && result_stall)) begin
          if (status.can_emit) begin
            cmd.emit          = 1'b1;
            result_valid_next = 1'b1;
            if (!status.more) begin
              state_next = ST_IDLE;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/utf8_stream_decoder.sv */
// utf-8 stream decoder top level: one byte per transaction in, code points out
// order: a byte is loaded in the idle state, then its results are registered from the run state
// no new byte is taken while results are still being stepped out (item_stall in the run state);
//   one result per cycle, unless result_stall holds it, from the single decode unit over the pending buffer
// reset: synchronous active high; empties the pending buffer and drops any result
`default_nettype none
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire in_item_t  item,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_item_t      result
);

  u8d_cmd_t    cmd;
  u8d_status_t status;

  u8d_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  u8d_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
`default_nettype wire
